// File: design/bdb_pkg.sv
// Package for the button debouncer: the input beat and result beat types
// and the widths shared by the stages. No dependencies.
`timescale 1ns / 1ps

package bdb_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WINDOW_W = 16;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned STATE_W  = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd30;

    // One input beat: raw pin level (0 pressed) and the millisecond time.
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              raw_level;
    } bdb_item_t;

    // One result beat, taken after the state update.
    typedef struct packed {
        logic [COUNT_W-1:0] bounce_total;
        logic [STATE_W-1:0] machine_state;
        logic               pressed_stable;
    } bdb_result_t;

endpackage

// File: design/bdb_in_stage.sv
// Input register of the button debouncer: captures one beat from the slave
// side and holds it until the step logic takes it. Uses bdb_pkg.
`timescale 1ns / 1ps

module bdb_in_stage import bdb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bdb_item_t s_item,
    input  logic      take,
    output logic      item_valid,
    output bdb_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    bdb_item_t item_reg;

    // The register frees up in the same cycle that its beat moves on.
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/bdb_step.sv
// Debounce state machine: the window register, the four-state machine, the
// window start time, the previous level and the bounce counter. Uses bdb_pkg.
`timescale 1ns / 1ps

module bdb_step import bdb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [WINDOW_W-1:0] cfg_data,
    input  logic                fire,
    input  bdb_item_t           item,
    output bdb_result_t         result
);

    typedef enum logic [STATE_W-1:0] {
        PH_IDLE        = 2'd0,
        PH_DEB_PRESS   = 2'd1,
        PH_PRESSED     = 2'd2,
        PH_DEB_RELEASE = 2'd3
    } phase_t;

    logic [WINDOW_W-1:0] window_reg;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [TIME_W-1:0]   start_reg;
    logic [TIME_W-1:0]   start_next;
    logic                prev_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                stable_reg;
    logic                stable_next;
    logic [TIME_W-1:0]   elapsed;
    logic                window_done;
    logic                level_change;

    assign elapsed      = item.now_ms - start_reg;
    assign window_done  = elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, window_reg};
    assign level_change = item.raw_level != prev_reg;

    always_comb begin
        phase_next  = phase_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        stable_next = stable_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (!item.raw_level && prev_reg) begin
                    phase_next = PH_DEB_PRESS;
                    start_next = item.now_ms;
                    count_next = count_reg + 1'b1;
                end
            end
            PH_DEB_PRESS: begin
                if (level_change) begin
                    count_next = count_reg + 1'b1;
                end
                if (window_done) begin
                    if (!item.raw_level) begin
                        phase_next  = PH_PRESSED;
                        stable_next = 1'b1;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_PRESSED: begin
                if (item.raw_level && !prev_reg) begin
                    phase_next = PH_DEB_RELEASE;
                    start_next = item.now_ms;
                    count_next = count_reg + 1'b1;
                end
            end
            PH_DEB_RELEASE: begin
                if (level_change) begin
                    count_next = count_reg + 1'b1;
                end
                if (window_done) begin
                    if (item.raw_level) begin
                        phase_next  = PH_IDLE;
                        stable_next = 1'b0;
                    end else begin
                        phase_next = PH_PRESSED;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            phase_reg  <= PH_IDLE;
            start_reg  <= '0;
            prev_reg   <= 1'b1;
            count_reg  <= '0;
            stable_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                window_reg <= cfg_data;
            end
            if (fire) begin
                phase_reg  <= phase_next;
                start_reg  <= start_next;
                prev_reg   <= item.raw_level;
                count_reg  <= count_next;
                stable_reg <= stable_next;
            end
        end
    end

    // The result carries the state as it stands after this beat's update.
    assign result.pressed_stable = stable_next;
    assign result.machine_state  = phase_next;
    assign result.bounce_total   = count_next;

    // The debounced level is set exactly in the pressed half of the machine.
    a_stable_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        stable_reg == (phase_reg == PH_PRESSED || phase_reg == PH_DEB_RELEASE))
        else $error("debounced level disagrees with machine state");

    // The counter moves by at most one per beat and never without a beat.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 $past(aresetn) |->
        (count_reg == $past(count_reg) ||
         (count_reg == $past(count_reg) + 1'b1 && $past(fire))))
        else $error("bounce counter moved unexpectedly");

    // A new window start is recorded only on entering a debounce state.
    a_start_on_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 $past(aresetn) && start_reg != $past(start_reg) |->
        (phase_reg == PH_DEB_PRESS || phase_reg == PH_DEB_RELEASE))
        else $error("window start changed outside a window entry");

endmodule

// File: design/bdb_out_stage.sv
// Result register of the button debouncer: holds one result beat for the
// master side while the next item is already being taken. Uses bdb_pkg.
`timescale 1ns / 1ps

module bdb_out_stage import bdb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  bdb_result_t result,
    output logic        take,
    output logic        m_valid,
    input  logic        m_ready,
    output bdb_result_t m_result
);

    logic        valid_reg;
    logic        valid_next;
    bdb_result_t result_reg;

    // A beat moves in when the register is empty or is emptied this cycle.
    assign take = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// File: design/button_debounce_fsm.sv
// Top level of the timed button debouncer with a bounce counter.
// Depends on bdb_pkg, bdb_in_stage, bdb_step and bdb_out_stage.
//
//   Channel  Direction  Payload (lowest bit first)
//   s_       in         raw_level[0], now_ms[32:1], zero pad[39:33]
//   m_       out        pressed_stable[0], machine_state[2:1],
//                       bounce_total[18:3], zero pad[23:19]
//   cfg_     in         window_ms[15:0]
//
// Every input beat yields one result beat, and while m_tready is high a new
// beat can be accepted in every cycle. The whole update is one pass through
// the state machine between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers, puts the machine in
// idle with a released previous level and sets the window to 30 ms.
// While m_tready is low the result is held and the input register fills; after
// that s_tready drops until the result is taken.
`timescale 1ns / 1ps

module button_debounce_fsm import bdb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // raw_level, now_ms, pad
    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // pressed_stable, machine_state, bounce_total, pad
    // Debounce window register, in milliseconds.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WINDOW_W-1:0] cfg_data
);

    bdb_item_t   s_item;
    bdb_item_t   item;
    logic        item_valid;
    logic        take;
    bdb_result_t result;
    bdb_result_t m_result;

    // The window register can be written in any cycle; the user writes it only
    // while the block holds no beat.
    assign cfg_ready = 1'b1;

    assign s_item.raw_level = s_tdata[0];
    assign s_item.now_ms    = s_tdata[TIME_W:1];

    bdb_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // The state advances exactly when a beat moves into the result register.
    bdb_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .fire      (take),
        .item      (item),
        .result    (result)
    );

    bdb_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .take       (take),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (m_result)
    );

    assign m_tdata = {5'b0, m_result.bounce_total, m_result.machine_state,
                      m_result.pressed_stable};

endmodule
